### rtl/core/kntb4_pkg.sv
package kntb4_pkg;

   localparam int NUM_W      = 56;
   localparam int SUM_W      = 62;
   localparam int MAX_DIGITS = 28;
   localparam int SLOT_W     = 5;
   localparam int DIGIT_W    = 2;
   localparam int RSP_W      = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_LOAD,
      ST_STEP,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;       // capture the incoming number
      logic size;       // register the digit count, clear sum and pointers
      logic load;       // write one digit into the ring and add it to the sum
      logic step;       // one recurrence step
      logic res_clear;  // result is false (fewer than two digits)
      logic res_hit;    // result is the exact-match flag
      logic emit;       // move the result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic short_num;  // fewer than two digits
      logic load_last;  // the digit being loaded is the last one
      logic reached;    // the current term has reached or passed the number
      logic match;      // the current term equals the number
      logic result;     // latched answer
   } sts_type;

endpackage

### rtl/core/kntb4_ctrl.sv
module kntb4_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               out_free,
   input  kntb4_pkg::sts_type sts,
   output logic               req_ready,
   output kntb4_pkg::cmd_type cmd
);

   kntb4_pkg::state_type state_ff;
   kntb4_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kntb4_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kntb4_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = kntb4_pkg::ST_COUNT;
            end
         end
         kntb4_pkg::ST_COUNT: begin
            state_in = kntb4_pkg::ST_LOAD;
         end
         kntb4_pkg::ST_LOAD: begin
            if (sts.short_num) begin
               state_in = kntb4_pkg::ST_EMIT;
            end else if (sts.load_last) begin
               state_in = kntb4_pkg::ST_STEP;
            end
         end
         kntb4_pkg::ST_STEP: begin
            if (sts.reached) begin
               state_in = kntb4_pkg::ST_EMIT;
            end
         end
         kntb4_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = kntb4_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kntb4_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         kntb4_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         kntb4_pkg::ST_COUNT: begin
            cmd.size = 1'b1;
         end
         kntb4_pkg::ST_LOAD: begin
            if (sts.short_num) begin
               cmd.res_clear = 1'b1;
            end else begin
               cmd.load = 1'b1;
            end
         end
         kntb4_pkg::ST_STEP: begin
            if (sts.reached) begin
               cmd.res_hit = 1'b1;
            end else begin
               cmd.step = 1'b1;
            end
         end
         kntb4_pkg::ST_EMIT: begin
            cmd.emit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/core/kntb4_dp.sv
module kntb4_dp (
   input  logic                             clock,
   input  logic [kntb4_pkg::NUM_W-1:0]      number,
   input  kntb4_pkg::cmd_type               cmd,
   output kntb4_pkg::sts_type               sts
);

   logic [kntb4_pkg::NUM_W-1:0]   num_ff;
   logic [kntb4_pkg::SLOT_W-1:0]  k_ff;
   logic [kntb4_pkg::SLOT_W-1:0]  k_in;
   logic [kntb4_pkg::SLOT_W-1:0]  idx_ff;
   logic [kntb4_pkg::SLOT_W-1:0]  oldest_ff;
   logic [kntb4_pkg::SUM_W-1:0]   sum_ff;
   logic                          result_ff;
   logic [kntb4_pkg::NUM_W-1:0]   ring_ff [0:kntb4_pkg::MAX_DIGITS-1];

   logic [kntb4_pkg::SLOT_W-1:0]  digit_pos;
   logic [kntb4_pkg::DIGIT_W-1:0] digit;
   logic [kntb4_pkg::NUM_W-1:0]   oldest_term;
   logic [kntb4_pkg::SUM_W-1:0]   num_wide;

   // Leading nonzero digit gives the digit count; zero and one-digit numbers give 1.
   always_comb begin
      k_in = kntb4_pkg::SLOT_W'(1);
      for (int j = 1; j < kntb4_pkg::MAX_DIGITS; j++) begin
         if (num_ff[2*j +: kntb4_pkg::DIGIT_W] != '0) begin
            k_in = kntb4_pkg::SLOT_W'(j + 1);
         end
      end
   end

   // Digits go in most significant first.
   assign digit_pos   = k_ff - idx_ff - kntb4_pkg::SLOT_W'(1);
   assign digit       = num_ff[{digit_pos, 1'b0} +: kntb4_pkg::DIGIT_W];
   assign oldest_term = ring_ff[oldest_ff];
   assign num_wide    = {{(kntb4_pkg::SUM_W - kntb4_pkg::NUM_W){1'b0}}, num_ff};

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         num_ff <= number;
      end
      if (cmd.size) begin
         k_ff      <= k_in;
         idx_ff    <= '0;
         oldest_ff <= '0;
         sum_ff    <= '0;
      end
      if (cmd.load) begin
         ring_ff[idx_ff] <= {{(kntb4_pkg::NUM_W - kntb4_pkg::DIGIT_W){1'b0}}, digit};
         sum_ff          <= sum_ff + {{(kntb4_pkg::SUM_W - kntb4_pkg::DIGIT_W){1'b0}}, digit};
         idx_ff          <= idx_ff + kntb4_pkg::SLOT_W'(1);
      end
      if (cmd.step) begin
         // New term is the sum of the last k terms; it replaces the oldest one.
         ring_ff[oldest_ff] <= sum_ff[kntb4_pkg::NUM_W-1:0];
         sum_ff <= {sum_ff[kntb4_pkg::SUM_W-2:0], 1'b0}
                   - {{(kntb4_pkg::SUM_W - kntb4_pkg::NUM_W){1'b0}}, oldest_term};
         if (oldest_ff == k_ff - kntb4_pkg::SLOT_W'(1)) begin
            oldest_ff <= '0;
         end else begin
            oldest_ff <= oldest_ff + kntb4_pkg::SLOT_W'(1);
         end
      end
      if (cmd.res_clear) begin
         result_ff <= 1'b0;
      end else if (cmd.res_hit) begin
         result_ff <= sts.match;
      end
   end

   assign sts.short_num = (k_ff < kntb4_pkg::SLOT_W'(2));
   assign sts.load_last = (idx_ff == k_ff - kntb4_pkg::SLOT_W'(1));
   assign sts.reached   = (sum_ff >= num_wide);
   assign sts.match     = (sum_ff == num_wide);
   assign sts.result    = result_ff;

endmodule

### rtl/core/keith_number_test_base4_unit.sv
// Base-4 Keith number tester. Each transfer on the req_ channel carries one
// 56-bit candidate; for each one the block returns exactly one transfer on the
// rsp_ channel whose bit 0 is set when the candidate is a base-4 Keith number.
// Candidates below 4 (a single digit) always answer 0. One candidate is worked
// on at a time: after its transfer its k base-4 digits are counted, then loaded
// into the ring most significant first while being summed, then recurrence
// steps run until a term reaches or passes the candidate, and the result then
// enters the output register. Each step updates the running sum, doubled less
// the oldest term, and the digit load writes one ring entry per cycle. A fresh
// candidate is taken while an earlier result still waits in the output register,
// but the work does not finish into that register until it has been taken.
module keith_number_test_base4_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [kntb4_pkg::NUM_W-1:0]   req_tdata,   // [55:0] number
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [kntb4_pkg::RSP_W-1:0]   rsp_tdata    // [0] is_keith, [7:1] zero
);

   kntb4_pkg::cmd_type cmd;
   kntb4_pkg::sts_type sts;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_bit_ff;
   logic                        out_free;

   // The output register can be loaded when empty or when its result is
   // being transferred in this same cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   kntb4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .sts       (sts),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   kntb4_dp u_dp (
      .clock  (clock),
      .number (req_tdata),
      .cmd    (cmd),
      .sts    (sts)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_bit_ff <= sts.result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(kntb4_pkg::RSP_W - 1){1'b0}}, rsp_bit_ff};

   // A result must never overwrite one that has not been transferred.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending one");

   // After taking a candidate the block is busy and cannot take another.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second candidate taken while busy");

   // No result can be produced in the cycle right after a candidate arrives.
   a_no_early_emit: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !cmd.emit)
      else $error("result emitted too early");

endmodule
